FILE: rtl/core/jsu_pkg.sv
package jsu_pkg;

	// Result kinds carried on the output tuser field.
	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_DONE = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	// Decoder modes, one-hot.
	typedef enum logic [6:0] {
		MODE_WAIT   = 7'b0000001,
		MODE_STR    = 7'b0000010,
		MODE_ESC    = 7'b0000100,
		MODE_HEX1   = 7'b0001000,
		MODE_PEND   = 7'b0010000,
		MODE_PENDBS = 7'b0100000,
		MODE_HEX2   = 7'b1000000
	} mode_t;

	// Characters that steer the decoder.
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;

	// Control characters that the short escapes stand for.
	localparam logic [7:0] CTL_BS = 8'h08;
	localparam logic [7:0] CTL_FF = 8'h0C;
	localparam logic [7:0] CTL_LF = 8'h0A;
	localparam logic [7:0] CTL_CR = 8'h0D;
	localparam logic [7:0] CTL_HT = 8'h09;

	// Surrogate ranges and UTF-8 size limits.
	localparam logic [15:0] HI_SURR_MIN = 16'hD800;
	localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
	localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
	localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE   = 21'h10000;
	localparam logic [20:0] LIM_1BYTE   = 21'h00080;
	localparam logic [20:0] LIM_2BYTE   = 21'h00800;

	// Last hex digit position within a \u escape.
	localparam logic [1:0] HEX_LAST = 2'd3;

	// One optional trailing result of a step and the state change it brings.
	typedef struct packed {
		logic       vld;
		kind_t      kind;
		logic [7:0] data;
		mode_t      mode;
		logic       idle;
		logic       clr_first;
	} tail_t;

	localparam tail_t TAIL_ERR = '{vld: 1'b1, kind: KIND_ERR, data: 8'h00,
		mode: MODE_WAIT, idle: 1'b1, clr_first: 1'b0};

	// Up to four results caused by one input item.
	typedef struct packed {
		logic [1:0]      lst;
		kind_t [3:0]     kind;
		logic [3:0][7:0] data;
	} grp_t;

	// Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/json_string_unescape_utf8.sv
// Decodes the text of a quoted JSON string, one raw byte per item on the slave
// side, into UTF-8 bytes on the master side, each tagged in tuser as a decoded
// byte, string complete or error, with tlast on the final result of each input
// byte. A byte is accepted in every cycle except while both queue entries are
// occupied; its results are decided in the cycle it is taken and registered
// into a two-deep queue of result groups, which gives one result per cycle
// while m_tready is high. An escape that expands to two, three or four UTF-8
// bytes yields as many results from one queue entry. Bytes inside an escape
// that give no result (backslash, hex digits) use no queue entry.
module json_string_unescape_utf8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [1:0] m_tuser,   // [1:0] kind
	output logic       m_tlast
);
	import jsu_pkg::*;

	mode_t       mode_q, mode_d;
	logic [1:0]  hc_q, hc_d;
	logic [15:0] first_q, first_d;
	logic [15:0] second_q, second_d;

	logic        in_fire;
	logic [7:0]  c;
	tail_t       sb, el, tl;
	logic        use_tl;
	logic [4:0]  hd;
	logic [15:0] new1, new2;
	logic        do_enc;
	logic [20:0] enc_cp;
	logic [2:0]  enc_len, e_len, n_res;
	logic [3:0][7:0] enc_b;
	grp_t        grp_new;

	grp_t        gq_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  fill_q;
	logic [1:0]  idx_q;
	grp_t        head;
	logic        push, pop, out_fire;

	assign c       = s_tdata;
	assign in_fire = s_tvalid && s_tready;

	// Result of handling c as an ordinary string byte.
	always_comb begin
		sb = '{vld: 1'b1, kind: KIND_BYTE, data: c, mode: MODE_STR,
			idle: 1'b0, clr_first: 1'b0};
		if (c == CH_NUL) begin
			sb = TAIL_ERR;
		end else if (c == CH_QUOTE) begin
			sb.kind = KIND_DONE;
			sb.data = 8'h00;
			sb.mode = MODE_WAIT;
			sb.idle = 1'b1;
		end else if (c == CH_BSLASH) begin
			sb.vld  = 1'b0;
			sb.mode = MODE_ESC;
		end
	end

	// Result of handling c as the letter after a backslash.
	always_comb begin
		el = '{vld: 1'b1, kind: KIND_BYTE, data: c, mode: MODE_STR,
			idle: 1'b0, clr_first: 1'b0};
		case (c)
			CH_QUOTE, CH_BSLASH, CH_SLASH: el.data = c;
			CH_B: el.data = CTL_BS;
			CH_F: el.data = CTL_FF;
			CH_N: el.data = CTL_LF;
			CH_R: el.data = CTL_CR;
			CH_T: el.data = CTL_HT;
			CH_U: begin
				el.vld       = 1'b0;
				el.mode      = MODE_HEX1;
				el.clr_first = 1'b1;
			end
			default: el = TAIL_ERR;
		endcase
	end

	assign hd   = hex_decode(c);
	assign new1 = {first_q[11:0], hd[3:0]};
	assign new2 = {second_q[11:0], hd[3:0]};

	// Next state and the code point to encode for the current item.
	always_comb begin
		mode_d   = mode_q;
		hc_d     = hc_q;
		first_d  = first_q;
		second_d = second_q;
		do_enc   = 1'b0;
		enc_cp   = {5'd0, first_q};
		tl       = sb;
		use_tl   = 1'b0;
		case (mode_q)
			MODE_STR: begin
				use_tl = 1'b1;
			end
			MODE_ESC: begin
				tl     = el;
				use_tl = 1'b1;
			end
			MODE_HEX1, MODE_HEX2: begin
				if (!hd[4]) begin
					tl     = TAIL_ERR;
					use_tl = 1'b1;
				end else begin
					if (mode_q == MODE_HEX1) begin
						first_d = new1;
					end else begin
						second_d = new2;
					end
					if (hc_q != HEX_LAST) begin
						hc_d = hc_q + 2'd1;
					end else begin
						hc_d = 2'd0;
						if (mode_q == MODE_HEX1) begin
							if (new1 >= HI_SURR_MIN && new1 <= HI_SURR_MAX) begin
								mode_d = MODE_PEND;
							end else begin
								do_enc = 1'b1;
								enc_cp = {5'd0, new1};
								mode_d = MODE_STR;
							end
						end else begin
							// Join the pair when the second value is a low surrogate.
							do_enc = 1'b1;
							if (new2 >= LO_SURR_MIN && new2 <= LO_SURR_MAX) begin
								enc_cp = SUPP_BASE + {1'b0, first_q[9:0], new2[9:0]};
							end
							mode_d = MODE_STR;
						end
					end
				end
			end
			MODE_PEND: begin
				if (c == CH_BSLASH) begin
					mode_d = MODE_PENDBS;
				end else begin
					do_enc = 1'b1;
					use_tl = 1'b1;
				end
			end
			MODE_PENDBS: begin
				if (c == CH_U) begin
					mode_d   = MODE_HEX2;
					hc_d     = 2'd0;
					second_d = 16'd0;
				end else begin
					do_enc = 1'b1;
					tl     = el;
					use_tl = 1'b1;
				end
			end
			default: begin
				// Waiting for the opening quote; unused codes act the same.
				if (c == CH_QUOTE) begin
					mode_d   = MODE_STR;
					hc_d     = 2'd0;
					first_d  = 16'd0;
					second_d = 16'd0;
				end else begin
					tl     = TAIL_ERR;
					use_tl = 1'b1;
				end
			end
		endcase
		if (use_tl) begin
			mode_d = tl.mode;
			if (tl.idle) begin
				hc_d     = 2'd0;
				first_d  = 16'd0;
				second_d = 16'd0;
			end
			if (tl.clr_first) begin
				hc_d    = 2'd0;
				first_d = 16'd0;
			end
		end
	end

	// UTF-8 encoding of the code point.
	always_comb begin
		enc_b = '0;
		if (enc_cp < LIM_1BYTE) begin
			enc_len  = 3'd1;
			enc_b[0] = enc_cp[7:0];
		end else if (enc_cp < LIM_2BYTE) begin
			enc_len  = 3'd2;
			enc_b[0] = {3'b110, enc_cp[10:6]};
			enc_b[1] = {2'b10, enc_cp[5:0]};
		end else if (enc_cp < SUPP_BASE) begin
			enc_len  = 3'd3;
			enc_b[0] = {4'b1110, enc_cp[15:12]};
			enc_b[1] = {2'b10, enc_cp[11:6]};
			enc_b[2] = {2'b10, enc_cp[5:0]};
		end else begin
			enc_len  = 3'd4;
			enc_b[0] = {5'b11110, enc_cp[20:18]};
			enc_b[1] = {2'b10, enc_cp[17:12]};
			enc_b[2] = {2'b10, enc_cp[11:6]};
			enc_b[3] = {2'b10, enc_cp[5:0]};
		end
	end

	// Encoded bytes first, then the trailing result if there is one.
	assign e_len = do_enc ? enc_len : 3'd0;
	assign n_res = e_len + {2'd0, use_tl && tl.vld};

	always_comb begin
		grp_new     = '0;
		grp_new.lst = n_res[1:0] - 2'd1;
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < e_len) begin
				grp_new.kind[i] = KIND_BYTE;
				grp_new.data[i] = enc_b[i];
			end else begin
				grp_new.kind[i] = tl.kind;
				grp_new.data[i] = tl.data;
			end
		end
	end

	// Decoder state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_WAIT;
			hc_q     <= 2'd0;
			first_q  <= 16'd0;
			second_q <= 16'd0;
		end else if (in_fire) begin
			mode_q   <= mode_d;
			hc_q     <= hc_d;
			first_q  <= first_d;
			second_q <= second_d;
		end
	end

	// Result group queue and output handshake.
	assign s_tready = (fill_q != 2'd2);
	assign push     = in_fire && (n_res != 3'd0);
	assign head     = gq_q[rd_ptr_q];
	assign m_tvalid = (fill_q != 2'd0);
	assign m_tdata  = head.data[idx_q];
	assign m_tuser  = head.kind[idx_q];
	assign m_tlast  = (idx_q == head.lst);
	assign out_fire = m_tvalid && m_tready;
	assign pop      = out_fire && m_tlast;

	always_ff @(posedge clk) begin
		if (push) begin
			gq_q[wr_ptr_q] <= grp_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
			idx_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (out_fire) begin
				if (m_tlast) begin
					idx_q    <= 2'd0;
					rd_ptr_q <= ~rd_ptr_q;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	// The queue never holds more than two groups.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3)
		else $error("result queue overfilled");

	// The read index stays within the head group.
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (idx_q <= head.lst))
		else $error("result index beyond group");

	// An error result always sends the decoder back to waiting for a quote.
	a_err_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(push && use_tl && tl.kind == KIND_ERR) |=> (mode_q == MODE_WAIT && first_q == 16'd0))
		else $error("decoder not idle after error");

	// An empty queue with no push stays empty.
	a_empty_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == 2'd0 && !push) |=> (fill_q == 2'd0))
		else $error("queue filled without a push");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
	import jsu_pkg::*;

	// Receiver hold-off length and the watchdog limit, in clock cycles.
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;
	localparam int CHUNK_ITEMS = 120;

	// One expected decoder result.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       is_last;
	} result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;   // [7:0] in_byte
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // [7:0] out_byte
	logic [1:0] m_tuser;           // [1:0] kind
	logic       m_tlast;

	// Raw string text waiting to be sent, and decoded results still to come.
	logic [7:0] raw_text_q[$];
	result_t    utf8_expect_q[$];

	// Decoder state as the checker sees it.
	mode_t       dec_mode = MODE_WAIT;
	logic [1:0]  hex_cnt = 2'd0;
	logic [15:0] code_hi = 16'h0000;
	logic [15:0] code_lo = 16'h0000;
	result_t     step_out[4];
	int          step_n;

	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	logic hold_req = 1'b0;
	logic hold_taken = 1'b0;
	int   hold_left = 0;
	int   n_bad = 0;
	int   idle_cycles = 0;
	int   n_pushed = 0;
	result_t want;

	logic [7:0] esc_letters[8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

	json_string_unescape_utf8 dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Decoder prediction
	// ---------------------------------------------------------------------

	// Bit 4 marks a hex digit, bits 3:0 give its value.
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [7:0] v;
		v = 8'hFF;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = c - 8'h61 + 8'd10;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = c - 8'h41 + 8'd10;
		end
		return (v == 8'hFF) ? 5'd0 : {1'b1, v[3:0]};
	endfunction

	task automatic emit(input kind_t k, input logic [7:0] b);
		step_out[step_n] = '{kind: k, data: (k == KIND_BYTE) ? b : 8'h00, is_last: 1'b0};
		step_n++;
	endtask

	task automatic back_to_wait();
		dec_mode = MODE_WAIT;
		hex_cnt  = 2'd0;
		code_hi  = 16'h0000;
		code_lo  = 16'h0000;
	endtask

	// Writes one code point as one to four UTF-8 bytes.
	task automatic emit_utf8(input logic [20:0] cp);
		if (cp < LIM_1BYTE) begin
			emit(KIND_BYTE, cp[7:0]);
		end else if (cp < LIM_2BYTE) begin
			emit(KIND_BYTE, {3'b110, cp[10:6]});
			emit(KIND_BYTE, {2'b10, cp[5:0]});
		end else if (cp < SUPP_BASE) begin
			emit(KIND_BYTE, {4'b1110, cp[15:12]});
			emit(KIND_BYTE, {2'b10, cp[11:6]});
			emit(KIND_BYTE, {2'b10, cp[5:0]});
		end else begin
			emit(KIND_BYTE, {5'b11110, cp[20:18]});
			emit(KIND_BYTE, {2'b10, cp[17:12]});
			emit(KIND_BYTE, {2'b10, cp[11:6]});
			emit(KIND_BYTE, {2'b10, cp[5:0]});
		end
	endtask

	// A byte inside the string body.
	task automatic body_byte(input logic [7:0] c);
		if (c == CH_NUL) begin
			back_to_wait();
			emit(KIND_ERR, 8'h00);
		end else if (c == CH_QUOTE) begin
			back_to_wait();
			emit(KIND_DONE, 8'h00);
		end else if (c == CH_BSLASH) begin
			dec_mode = MODE_ESC;
		end else begin
			dec_mode = MODE_STR;
			emit(KIND_BYTE, c);
		end
	endtask

	// The letter after a backslash.
	task automatic escape_byte(input logic [7:0] c);
		logic [7:0] v;
		v = c;
		case (c)
			CH_QUOTE, CH_BSLASH, CH_SLASH: v = c;
			CH_B: v = CTL_BS;
			CH_F: v = CTL_FF;
			CH_N: v = CTL_LF;
			CH_R: v = CTL_CR;
			CH_T: v = CTL_HT;
			CH_U: begin
				dec_mode = MODE_HEX1;
				hex_cnt  = 2'd0;
				code_hi  = 16'h0000;
				return;
			end
			default: begin
				back_to_wait();
				emit(KIND_ERR, 8'h00);
				return;
			end
		endcase
		dec_mode = MODE_STR;
		emit(KIND_BYTE, v);
	endtask

	// Advances the decoder by one raw byte and queues the results it causes.
	task automatic unescape_step(input logic [7:0] c);
		logic [4:0]  nib;
		logic [20:0] cp;
		step_n = 0;
		case (dec_mode)
			MODE_STR: body_byte(c);
			MODE_ESC: escape_byte(c);
			MODE_HEX1, MODE_HEX2: begin
				nib = hex_nibble(c);
				if (!nib[4]) begin
					back_to_wait();
					emit(KIND_ERR, 8'h00);
				end else begin
					if (dec_mode == MODE_HEX1) begin
						code_hi = {code_hi[11:0], nib[3:0]};
					end else begin
						code_lo = {code_lo[11:0], nib[3:0]};
					end
					if (hex_cnt != HEX_LAST) begin
						hex_cnt = hex_cnt + 2'd1;
					end else begin
						hex_cnt = 2'd0;
						if (dec_mode == MODE_HEX1) begin
							if (code_hi >= HI_SURR_MIN && code_hi <= HI_SURR_MAX) begin
								dec_mode = MODE_PEND;
							end else begin
								emit_utf8({5'd0, code_hi});
								dec_mode = MODE_STR;
							end
						end else begin
							cp = {5'd0, code_hi};
							// A low surrogate completes the pair; anything else is dropped.
							if (code_lo >= LO_SURR_MIN && code_lo <= LO_SURR_MAX) begin
								cp = SUPP_BASE + (({5'd0, code_hi} - {5'd0, HI_SURR_MIN}) << 10)
									+ ({5'd0, code_lo} - {5'd0, LO_SURR_MIN});
							end
							emit_utf8(cp);
							dec_mode = MODE_STR;
						end
					end
				end
			end
			MODE_PEND: begin
				if (c == CH_BSLASH) begin
					dec_mode = MODE_PENDBS;
				end else begin
					emit_utf8({5'd0, code_hi});
					body_byte(c);
				end
			end
			MODE_PENDBS: begin
				if (c == CH_U) begin
					dec_mode = MODE_HEX2;
					hex_cnt  = 2'd0;
					code_lo  = 16'h0000;
				end else begin
					emit_utf8({5'd0, code_hi});
					escape_byte(c);
				end
			end
			default: begin
				if (c == CH_QUOTE) begin
					back_to_wait();
					dec_mode = MODE_STR;
				end else begin
					back_to_wait();
					emit(KIND_ERR, 8'h00);
				end
			end
		endcase
		if (step_n > 0) begin
			step_out[step_n - 1].is_last = 1'b1;
		end
		for (int i = 0; i < step_n; i++) begin
			utf8_expect_q.push_back(step_out[i]);
		end
	endtask

	// ---------------------------------------------------------------------
	// Text generation
	// ---------------------------------------------------------------------

	task automatic push(input logic [7:0] c);
		raw_text_q.push_back(c);
		n_pushed++;
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) begin
			return 8'h30 + n;
		end
		return ($urandom_range(1) ? 8'h61 : 8'h41) + n - 8'd10;
	endfunction

	task automatic push_u(input logic [15:0] v);
		push(CH_BSLASH);
		push(CH_U);
		push(hex_char(v[15:12]));
		push(hex_char(v[11:8]));
		push(hex_char(v[7:4]));
		push(hex_char(v[3:0]));
	endtask

	function automatic logic [7:0] rand_plain();
		logic [7:0] c;
		c = 8'($urandom_range(1, 255));
		while (c == CH_QUOTE || c == CH_BSLASH) begin
			c = 8'($urandom_range(1, 255));
		end
		return c;
	endfunction

	function automatic logic [7:0] rand_bad_hex();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (hex_nibble(c) != 5'd0) begin
			c = 8'($urandom_range(0, 255));
		end
		return c;
	endfunction

	function automatic logic [7:0] rand_bad_escape();
		logic [7:0] c;
		logic       ok;
		ok = 1'b0;
		c = 8'h00;
		while (!ok) begin
			c = 8'($urandom_range(0, 255));
			ok = (c != CH_U);
			foreach (esc_letters[i]) begin
				if (c == esc_letters[i]) begin
					ok = 1'b0;
				end
			end
		end
		return c;
	endfunction

	// A code point that needs one, two or three UTF-8 bytes, never a high surrogate.
	function automatic logic [15:0] rand_bmp();
		logic [15:0] v;
		case ($urandom_range(3))
			0: v = 16'($urandom_range(0, 16'h007F));
			1: v = 16'($urandom_range(16'h0080, 16'h07FF));
			default: begin
				v = 16'($urandom_range(16'h0800, 16'hFFFF));
				while (v >= HI_SURR_MIN && v <= HI_SURR_MAX) begin
					v = 16'($urandom_range(16'h0800, 16'hFFFF));
				end
			end
		endcase
		return v;
	endfunction

	function automatic logic [15:0] rand_hi();
		return 16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX));
	endfunction

	function automatic logic [15:0] rand_lo();
		return 16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX));
	endfunction

	// One string body piece that keeps the string well formed.
	task automatic push_piece();
		logic [15:0] v;
		case ($urandom_range(11))
			0, 1, 2: push(rand_plain());
			3, 4: begin
				push(CH_BSLASH);
				push(esc_letters[3'($urandom_range(7))]);
			end
			5: push_u(rand_bmp());
			6, 7: begin
				push_u(rand_hi());
				push_u(rand_lo());
			end
			8: begin
				push_u(rand_hi());
				push(rand_plain());
			end
			9: begin
				push_u(rand_hi());
				push(CH_BSLASH);
				push(esc_letters[3'($urandom_range(7))]);
			end
			10: begin
				// Second escape is not a low surrogate, so it is dropped.
				push_u(rand_hi());
				v = $urandom_range(1) ? rand_hi() : rand_bmp();
				while (v >= LO_SURR_MIN && v <= LO_SURR_MAX) begin
					v = rand_bmp();
				end
				push_u(v);
			end
			default: push_u(rand_lo());
		endcase
	endtask

	// A string that ends in a decoding error instead of a closing quote.
	task automatic push_broken();
		int k;
		k = $urandom_range(3);
		case ($urandom_range(3))
			0: push(CH_NUL);
			1: begin
				push(CH_BSLASH);
				push(rand_bad_escape());
			end
			2: begin
				push(CH_BSLASH);
				push(CH_U);
				for (int i = 0; i < k; i++) begin
					push(hex_char(4'($urandom_range(15))));
				end
				push(rand_bad_hex());
			end
			default: begin
				push_u(rand_hi());
				push(CH_BSLASH);
				push(CH_U);
				for (int i = 0; i < k; i++) begin
					push(hex_char(4'($urandom_range(15))));
				end
				push(rand_bad_hex());
			end
		endcase
	endtask

	task automatic fill_random(input int target);
		int r;
		int pieces;
		while (n_pushed < target) begin
			r = $urandom_range(99);
			pieces = $urandom_range(0, 8);
			if (r < 80) begin
				push(CH_QUOTE);
				for (int i = 0; i < pieces; i++) begin
					push_piece();
				end
				push(CH_QUOTE);
			end else if (r < 92) begin
				push(CH_QUOTE);
				for (int i = 0; i < pieces / 2; i++) begin
					push_piece();
				end
				push_broken();
			end else begin
				// Arbitrary bytes; a NUL afterwards always returns to waiting.
				for (int i = 0; i < pieces + 1; i++) begin
					push(8'($urandom_range(0, 255)));
				end
				push(CH_NUL);
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Driver: offers raw bytes and predicts on every accepted item.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'h00;
		end else begin
			if (s_tvalid && s_tready) begin
				unescape_step(s_tdata);
			end
			if (!s_tvalid || s_tready) begin
				if (raw_text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= raw_text_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: checks every accepted result against the oldest expectation.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (utf8_expect_q.size() == 0) begin
					n_bad++;
					if (n_bad <= 10) begin
						$display("unexpected item: kind %0d byte %02h last %0b",
							m_tuser, m_tdata, m_tlast);
					end
				end else begin
					want = utf8_expect_q.pop_front();
					if (m_tuser !== want.kind || m_tdata !== want.data
							|| m_tlast !== want.is_last) begin
						n_bad++;
						if (n_bad <= 10) begin
							$display("mismatch: exp %0d/%02h/%0b got %0d/%02h/%0b",
								want.kind, want.data, want.is_last,
								m_tuser, m_tdata, m_tlast);
						end
					end
				end
			end
			// A long hold-off once, otherwise random stalls.
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else if (hold_req && !hold_taken) begin
				hold_taken <= 1'b1;
				hold_left  <= HOLD_CYCLES;
				m_tready   <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog on cycles where no item moves on either side.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------------------------------------------------------------
	// Sequence: reset, directed text, three random phases, drain.
	// ---------------------------------------------------------------------
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: junk and NUL while waiting, extremes, escapes, surrogates.
		push(8'h41);
		push(CH_NUL);
		push(CH_QUOTE);
		push(8'hFF);
		push(8'h01);
		push(CH_BSLASH);
		push(CH_T);
		push(CH_QUOTE);
		push(CH_QUOTE);
		push_u(16'h0000);
		push_u(16'hD83D);
		push_u(16'hDE00);
		push_u(16'hDBFF);
		push(CH_QUOTE);

		// Sender mostly busy, receiver mostly stalled.
		send_idle_pct <= 25;
		recv_idle_pct <= 87;
		fill_random(CHUNK_ITEMS);
		while (raw_text_q.size() != 0) @(posedge clk);

		// Roles swapped.
		send_idle_pct <= 87;
		recv_idle_pct <= 25;
		fill_random(2 * CHUNK_ITEMS);
		while (raw_text_q.size() != 0) @(posedge clk);

		// No idling, with one long receiver hold-off so the input backs up.
		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		hold_req      <= 1'b1;
		fill_random(3 * CHUNK_ITEMS);

		while (raw_text_q.size() != 0 || s_tvalid) @(posedge clk);
		while (utf8_expect_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		if (n_bad == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
